[sv/upr_pkg.sv]
// package for the pixel replication upscaler: widths, codes and shared types
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package upr_pkg;

  localparam int UPR_MAX_WIDTH = 1024;
  localparam int UPR_MAX_SCALE = 100;

  localparam int PIX_W    = 24;
  localparam int BYTE_W   = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int SCALE_W  = 7;
  localparam int ROW_W    = 12;
  localparam int PAD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;

  // queue between front and back, power of two
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic [STAT_W-1:0] ST_PIXEL     = 2'd0;
  localparam logic [STAT_W-1:0] ST_LOAD_OK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_LOAD_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_READY = 2'd3;

  localparam logic [1:0] REG_IN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE     = 2'd2;

  typedef struct packed {
    logic [WIDTH_W-1:0]  in_width;
    logic [HEIGHT_W-1:0] in_height;
    logic [SCALE_W-1:0]  scale;
    logic [PAD_W-1:0]    pad;
  } upr_cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PIX_W-1:0]  pixel;
    logic [PAD_W-1:0]  pad;
    logic              row_end;
    logic              image_end;
  } upr_op_t;

endpackage

[sv/upr_in_if.sv]
// request channel into the upscaler: load or emit command with pixel bytes
// depends on upr_pkg
`timescale 1ns / 1ps

interface upr_in_if import upr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] blue_in;
  logic [BYTE_W-1:0] green_in;
  logic [BYTE_W-1:0] red_in;

  modport source (output valid, cmd, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, cmd, blue_in, green_in, red_in, output ready);
endinterface

[sv/upr_out_if.sv]
// result channel out of the upscaler: status, pixel bytes and row markers
// depends on upr_pkg
`timescale 1ns / 1ps

interface upr_out_if import upr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] blue_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] red_out;
  logic [PAD_W-1:0]  pad_after;
  logic              row_end;
  logic              image_end;

  modport source (output valid, status, blue_out, green_out, red_out, pad_after,
                  row_end, image_end, input ready);
  modport sink   (input valid, status, blue_out, green_out, red_out, pad_after,
                  row_end, image_end, output ready);
endinterface

[sv/integer_pixel_replication_upscaler_top.sv]
// Nearest-neighbour integer upscaler for 24-bit RGB. Load requests fill a one-row
// line store; once the row is full, each emit request returns the next output pixel,
// every stored pixel repeated scale times across and the row scale times down, with
// the row alignment padding count on the last pixel of each output row. Every
// request gives exactly one result. One request is taken per clock, loads and emits
// alike, as long as results are taken; the rate is set by the single-port line
// store, which does one write or one read a cycle. Each request passes the line store
// read, the queue and the output register before its result. Registers in_width,
// in_height and scale sit at byte addresses 0, 4 and 8 and saturate on write; change
// them only with no requests in flight.
// depends on upr_pkg, upr_in_if, upr_out_if, upr_front, upr_fifo, upr_back
`timescale 1ns / 1ps

module integer_pixel_replication_upscaler_top import upr_pkg::*; #(
  parameter int MAX_WIDTH = UPR_MAX_WIDTH,
  parameter int MAX_SCALE = UPR_MAX_SCALE
) (
  input  logic              clk,
  input  logic              rst_n,
  upr_in_if.sink            in_ch,
  upr_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [WIDTH_W-1:0] WidthMax =
    (MAX_WIDTH > 2047) ? 11'd2047 : WIDTH_W'(MAX_WIDTH);
  localparam logic [SCALE_W-1:0] ScaleMax = SCALE_W'(MAX_SCALE);

  logic [WIDTH_W-1:0]  in_width_r;
  logic [HEIGHT_W-1:0] in_height_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [WIDTH_W-1:0]  wr_width;
  logic [HEIGHT_W-1:0] wr_height;
  logic [SCALE_W-1:0]  wr_scale;
  logic                cfg_wr;
  logic [5:0]          align_prod;
  upr_cfg_t            cfg;

  logic                push, pop, head_valid;
  upr_op_t             push_op, head_op;
  logic [CNT_W-1:0]    fifo_level;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    wr_width  = pwdata[WIDTH_W-1:0];
    wr_height = pwdata[HEIGHT_W-1:0];
    wr_scale  = pwdata[SCALE_W-1:0];
    if (wr_width == '0) begin
      wr_width = WIDTH_W'(1);
    end else if (wr_width > WidthMax) begin
      wr_width = WidthMax;
    end
    if (wr_height == '0) begin
      wr_height = HEIGHT_W'(1);
    end else if (wr_height > HEIGHT_MAX) begin
      wr_height = HEIGHT_MAX;
    end
    if (wr_scale == '0) begin
      wr_scale = SCALE_W'(1);
    end else if (wr_scale > ScaleMax) begin
      wr_scale = ScaleMax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= WIDTH_W'(1);
      in_height_r <= HEIGHT_W'(1);
      scale_r     <= SCALE_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_IN_WIDTH:  in_width_r  <= wr_width;
        REG_IN_HEIGHT: in_height_r <= wr_height;
        REG_SCALE:     scale_r     <= wr_scale;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IN_WIDTH:  prdata = DATA_W'(in_width_r);
      REG_IN_HEIGHT: prdata = DATA_W'(in_height_r);
      REG_SCALE:     prdata = DATA_W'(scale_r);
      default:       prdata = '0;
    endcase
  end

  // bytes per output row mod 4 only needs the low two bits of width and scale
  assign align_prod    = 6'(in_width_r[1:0]) * 6'(scale_r[1:0]) * 6'd3;
  assign cfg.in_width  = in_width_r;
  assign cfg.in_height = in_height_r;
  assign cfg.scale     = scale_r;
  assign cfg.pad       = PAD_W'(3'd4 - {1'b0, align_prod[1:0]});

  upr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .fifo_level (fifo_level),
    .push       (push),
    .push_op    (push_op)
  );

  upr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .level      (fifo_level)
  );

  upr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[sv/upr_front.sv]
// front end: accepts requests, runs the load and emit counters, owns the line store
// depends on upr_pkg and upr_in_if; feeds upr_fifo
`timescale 1ns / 1ps

module upr_front import upr_pkg::*; #(
  parameter int MAX_WIDTH = UPR_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  upr_in_if.sink           in_ch,
  input  upr_cfg_t         cfg,
  input  logic [CNT_W-1:0] fifo_level,
  output logic             push,
  output upr_op_t          push_op
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = ((AW > WIDTH_W) ? AW : WIDTH_W) + 1;

  logic [PIX_W-1:0]   line_mem_r [MAX_WIDTH];
  logic [PIX_W-1:0]   rd_data_r;

  logic [AW-1:0]      load_pos_r, load_pos_nxt;
  logic               row_ready_r, row_ready_nxt;
  logic [AW-1:0]      emit_col_r, emit_col_nxt;
  logic [SCALE_W-1:0] across_r, across_nxt;
  logic [SCALE_W-1:0] down_r, down_nxt;
  logic [ROW_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic               s1_valid_r;
  upr_op_t            s1_op_r;
  upr_op_t            op;

  logic               accept;
  logic               wr_en;
  logic               load_over, load_last, across_last, col_last, down_last, row_last;

  // room for the item in flight plus this one
  assign in_ch.ready = ({1'b0, fifo_level} + (CNT_W + 1)'(s1_valid_r))
                       < (CNT_W + 1)'(FIFO_DEPTH);
  assign accept = in_ch.valid && in_ch.ready;

  assign load_over   = CW'(load_pos_r) >= CW'(cfg.in_width);
  assign load_last   = (CW'(load_pos_r) + CW'(1)) >= CW'(cfg.in_width);
  assign col_last    = (CW'(emit_col_r) + CW'(1)) >= CW'(cfg.in_width);
  assign across_last = ({1'b0, across_r} + 8'd1) >= {1'b0, cfg.scale};
  assign down_last   = ({1'b0, down_r} + 8'd1) >= {1'b0, cfg.scale};
  assign row_last    = ({1'b0, row_cnt_r} + 13'd1) >= cfg.in_height;

  always_comb begin
    load_pos_nxt  = load_pos_r;
    row_ready_nxt = row_ready_r;
    emit_col_nxt  = emit_col_r;
    across_nxt    = across_r;
    down_nxt      = down_r;
    row_cnt_nxt   = row_cnt_r;
    op            = '0;
    wr_en         = 1'b0;
    if (accept) begin
      if (in_ch.cmd == CMD_LOAD) begin
        if (row_ready_r) begin
          op.status = ST_LOAD_FULL;
        end else if (load_over) begin
          // width shrank under the write position: treat the row as full
          op.status     = ST_LOAD_FULL;
          row_ready_nxt = 1'b1;
          load_pos_nxt  = '0;
        end else begin
          op.status = ST_LOAD_OK;
          wr_en     = 1'b1;
          if (load_last) begin
            load_pos_nxt  = '0;
            row_ready_nxt = 1'b1;
          end else begin
            load_pos_nxt = load_pos_r + AW'(1);
          end
        end
      end else if (!row_ready_r) begin
        op.status = ST_NOT_READY;
      end else begin
        op.status = ST_PIXEL;
        if (across_last) begin
          across_nxt = '0;
          if (col_last) begin
            emit_col_nxt = '0;
            op.row_end   = 1'b1;
            op.pad       = cfg.pad;
            if (down_last) begin
              down_nxt      = '0;
              row_ready_nxt = 1'b0;
              if (row_last) begin
                row_cnt_nxt  = '0;
                op.image_end = 1'b1;
              end else begin
                row_cnt_nxt = row_cnt_r + ROW_W'(1);
              end
            end else begin
              down_nxt = down_r + SCALE_W'(1);
            end
          end else begin
            emit_col_nxt = emit_col_r + AW'(1);
          end
        end else begin
          across_nxt = across_r + SCALE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r  <= '0;
      row_ready_r <= 1'b0;
      emit_col_r  <= '0;
      across_r    <= '0;
      down_r      <= '0;
      row_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      load_pos_r  <= load_pos_nxt;
      row_ready_r <= row_ready_nxt;
      emit_col_r  <= emit_col_nxt;
      across_r    <= across_nxt;
      down_r      <= down_nxt;
      row_cnt_r   <= row_cnt_nxt;
      s1_valid_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r <= op;
    end
  end

  // single port line store: one write on a stored load, else a read at the emit column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem_r[load_pos_r] <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
    end else begin
      rd_data_r <= line_mem_r[emit_col_r];
    end
  end

  always_comb begin
    push_op       = s1_op_r;
    push_op.pixel = rd_data_r;
  end
  assign push = s1_valid_r;

  a_full_row_pos: assert property (@(posedge clk) disable iff (!rst_n)
    row_ready_r |-> load_pos_r == '0)
    else $error("row held full with load position not at start");

  a_image_end_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_op_r.image_end |-> s1_op_r.row_end)
    else $error("image end without row end");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> fifo_level < CNT_W'(FIFO_DEPTH))
    else $error("front pushed into a full queue");

endmodule

[sv/upr_fifo.sv]
// short queue of classified requests between front and back
// depends on upr_pkg
`timescale 1ns / 1ps

module upr_fifo import upr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  upr_op_t          push_op,
  input  logic             pop,
  output logic             head_valid,
  output upr_op_t          head_op,
  output logic [CNT_W-1:0] level
);

  upr_op_t          entry_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  assign head_valid = count_r != '0;
  assign head_op    = entry_r[rd_ptr_r];
  assign level      = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r < CNT_W'(FIFO_DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue underflow");

endmodule

[sv/upr_back.sv]
// back end: takes classified requests off the queue and drives the result register
// depends on upr_pkg and upr_out_if
`timescale 1ns / 1ps

module upr_back import upr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  upr_op_t  head_op,
  output logic     pop,
  upr_out_if.source out_ch
);

  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [PIX_W-1:0]  pixel_r;
  logic [PAD_W-1:0]  pad_r;
  logic              row_end_r, image_end_r;

  assign pop = head_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r    <= head_op.status;
      // pixel bytes only go out with a pixel result
      pixel_r     <= (head_op.status == ST_PIXEL) ? head_op.pixel : '0;
      pad_r       <= head_op.pad;
      row_end_r   <= head_op.row_end;
      image_end_r <= head_op.image_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.blue_out  = pixel_r[BYTE_W-1:0];
  assign out_ch.green_out = pixel_r[2*BYTE_W-1:BYTE_W];
  assign out_ch.red_out   = pixel_r[3*BYTE_W-1:2*BYTE_W];
  assign out_ch.pad_after = pad_r;
  assign out_ch.row_end   = row_end_r;
  assign out_ch.image_end = image_end_r;

endmodule

[tb/testbench.sv]
// testbench for the integer pixel replication upscaler: directed and random requests
// checked against a cycle-free predictor; depends on upr_pkg, upr_in_if, upr_out_if
`timescale 1ns / 1ps

module testbench import upr_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic [PAD_W-1:0]  pad;
    logic              row_end;
    logic              image_end;
  } upscale_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  upr_in_if  in_if ();
  upr_out_if out_if ();

  integer_pixel_replication_upscaler_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and register copies
  logic [PIX_W-1:0] line_pix [UPR_MAX_WIDTH];
  int unsigned      load_pos   = 0;
  bit               row_full   = 0;
  int unsigned      col        = 0;
  int unsigned      copy_x     = 0;
  int unsigned      copy_y     = 0;
  int unsigned      row_idx    = 0;
  int unsigned      stored_len = 0;
  int unsigned      cfg_width  = 1;
  int unsigned      cfg_height = 1;
  int unsigned      cfg_scale  = 1;

  upscale_result_t replicated_q [$];
  int              err_count = 0;
  int              cycle_cnt = 0;
  bit              gap_on    = 1;
  bit              stall_on  = 1;
  int              hold_req  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(stall_on && $urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    upscale_result_t got;
    upscale_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.status, out_if.blue_out, out_if.green_out, out_if.red_out,
             out_if.pad_after, out_if.row_end, out_if.image_end};
      if (replicated_q.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, got);
        err_count++;
      end else begin
        want = replicated_q.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected st=%0d b=%h g=%h r=%h pad=%0d re=%b ie=%b",
                   $time, want.status, want.blue, want.green, want.red, want.pad,
                   want.row_end, want.image_end);
          $display("%0t            actual st=%0d b=%h g=%h r=%h pad=%0d re=%b ie=%b",
                   $time, got.status, got.blue, got.green, got.red, got.pad,
                   got.row_end, got.image_end);
          err_count++;
        end
      end
    end
  end

  task automatic replicate_step(input logic cmd, input logic [BYTE_W-1:0] b, g, r,
                                output upscale_result_t res);
    int unsigned pad_val;
    res = '0;
    if (cmd == CMD_LOAD) begin
      if (row_full) begin
        res.status = ST_LOAD_FULL;
      end else if (load_pos >= cfg_width || load_pos >= UPR_MAX_WIDTH) begin
        // width shrunk below the fill point: the row counts as full
        row_full   = 1;
        load_pos   = 0;
        res.status = ST_LOAD_FULL;
      end else begin
        line_pix[load_pos] = {r, g, b};
        load_pos++;
        if (load_pos > stored_len) stored_len = load_pos;
        if (load_pos >= cfg_width) begin
          load_pos = 0;
          row_full = 1;
        end
        res.status = ST_LOAD_OK;
      end
    end else if (!row_full) begin
      res.status = ST_NOT_READY;
    end else begin
      {res.red, res.green, res.blue} = line_pix[col];
      res.status = ST_PIXEL;
      if (copy_x + 1 >= cfg_scale) begin
        copy_x = 0;
        if (col + 1 >= cfg_width) begin
          col         = 0;
          res.row_end = 1'b1;
          pad_val     = (4 - (cfg_width * cfg_scale * 3) % 4) % 4;
          res.pad     = pad_val[PAD_W-1:0];
          if (copy_y + 1 >= cfg_scale) begin
            copy_y   = 0;
            row_full = 0;
            if (row_idx + 1 >= cfg_height) begin
              row_idx       = 0;
              res.image_end = 1'b1;
            end else begin
              row_idx++;
            end
          end else begin
            copy_y++;
          end
        end else begin
          col++;
        end
      end else begin
        copy_x++;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    int unsigned v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_IN_WIDTH: begin
        v = value & 32'h7FF;
        cfg_width = (v < 1) ? 1 : (v > UPR_MAX_WIDTH) ? UPR_MAX_WIDTH : v;
      end
      REG_IN_HEIGHT: begin
        v = value & 32'h1FFF;
        cfg_height = (v < 1) ? 1 : (v > HEIGHT_MAX) ? HEIGHT_MAX : v;
      end
      REG_SCALE: begin
        v = value & 32'h7F;
        cfg_scale = (v < 1) ? 1 : (v > UPR_MAX_SCALE) ? UPR_MAX_SCALE : v;
      end
      default: ;
    endcase
    // idle cycle so back-to-back writes never double-drive psel in one step
    @(posedge clk);
  endtask

  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b, g, r,
                           output logic [STAT_W-1:0] st);
    upscale_result_t res;
    int gap;
    gap = 0;
    if (gap_on && $urandom_range(0, 99) < 12) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.blue_in  <= b;
    in_if.green_in <= g;
    in_if.red_in   <= r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    replicate_step(cmd, b, g, r, res);
    replicated_q.push_back(res);
    st = res.status;
  endtask

  // mostly the request the image needs next, sometimes a random one
  task automatic send_stream_item(input int noise_pct, output logic [STAT_W-1:0] st);
    logic cmd;
    if ($urandom_range(0, 99) < noise_pct) cmd = 1'($urandom_range(0, 1));
    else cmd = row_full ? CMD_EMIT : CMD_LOAD;
    send_item(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), st);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (replicated_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    logic [STAT_W-1:0] st;
    send_item(CMD_EMIT, 8'h00, 8'h00, 8'h00, st);
    send_item(CMD_LOAD, 8'h00, 8'h00, 8'h00, st);
    send_item(CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, st);
    send_item(CMD_EMIT, 8'hFF, 8'hFF, 8'hFF, st);
    send_item(CMD_EMIT, 8'h00, 8'h00, 8'h00, st);
    send_item(CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, st);
    send_item(CMD_EMIT, 8'h00, 8'h00, 8'h00, st);
  endtask

  task automatic test_replication();
    logic [STAT_W-1:0] st;
    settle();
    write_reg(REG_IN_WIDTH, 32'd2);
    write_reg(REG_IN_HEIGHT, 32'd1);
    write_reg(REG_SCALE, 32'd2);
    send_item(CMD_LOAD, 8'hA5, 8'h5A, 8'hC3, st);
    send_item(CMD_LOAD, 8'h3C, 8'hF0, 8'h0F, st);
    send_item(CMD_LOAD, 8'h12, 8'h34, 8'h56, st);
    repeat (8) send_item(CMD_EMIT, 8'h00, 8'h00, 8'h00, st);
  endtask

  task automatic test_row_padding();
    logic [STAT_W-1:0] st;
    settle();
    write_reg(REG_IN_WIDTH, 32'd3);
    write_reg(REG_IN_HEIGHT, 32'd2);
    write_reg(REG_SCALE, 32'd1);
    repeat (6) send_stream_item(0, st);
  endtask

  task automatic test_random_images(input int target);
    int                done;
    int                kind;
    logic [DATA_W-1:0] raw_w;
    logic [DATA_W-1:0] raw_h;
    logic [DATA_W-1:0] raw_s;
    logic [STAT_W-1:0] st;
    done = 0;
    while (done < target) begin
      settle();
      kind  = $urandom_range(0, 9);
      raw_w = $urandom_range(1, 8);
      raw_h = $urandom_range(1, 3);
      raw_s = $urandom_range(1, 3);
      case (kind)
        6: begin
          case ($urandom_range(0, 2))
            0:       raw_w = 32'd1024;
            1:       raw_w = 32'h0000_07FF;
            default: raw_w = 32'hFFFF_FFFF;
          endcase
          raw_s = 32'd1;
        end
        7: begin
          raw_w = $urandom_range(1, 2);
          case ($urandom_range(0, 2))
            0:       raw_s = 32'd100;
            1:       raw_s = 32'h0000_007F;
            default: raw_s = 32'hFFFF_FF64;
          endcase
        end
        8: begin
          case ($urandom_range(0, 2))
            0:       raw_h = 32'd4096;
            1:       raw_h = 32'h0000_1FFF;
            default: raw_h = 32'd5000;
          endcase
        end
        9: begin
          raw_w = 32'd0;
          raw_h = 32'd0;
          raw_s = 32'd0;
        end
        default: ;
      endcase
      // a held row must not grow past the entries actually loaded
      if (row_full && raw_w > stored_len)
        raw_w = $urandom_range(1, (stored_len < 8) ? stored_len : 8);
      if (kind >= 6 || $urandom_range(0, 3) != 0) write_reg(REG_IN_WIDTH, raw_w);
      if (kind >= 6 || $urandom_range(0, 3) != 0) write_reg(REG_IN_HEIGHT, raw_h);
      if (kind >= 6 || $urandom_range(0, 3) != 0) write_reg(REG_SCALE, raw_s);
      repeat ($urandom_range(20, 100)) begin
        send_stream_item(12, st);
        if (st == ST_PIXEL || st == ST_LOAD_OK) done++;
      end
    end
  endtask

  task automatic test_no_idle_stretch();
    gap_on   = 0;
    stall_on = 0;
    test_random_images(120);
    gap_on   = 1;
    stall_on = 1;
  endtask

  task automatic test_output_hold_off();
    logic [STAT_W-1:0] st;
    settle();
    gap_on   = 0;
    hold_req = 300;
    repeat (60) send_stream_item(5, st);
    gap_on   = 1;
  endtask

  initial begin
    in_if.valid    <= 1'b0;
    in_if.cmd      <= CMD_LOAD;
    in_if.blue_in  <= '0;
    in_if.green_in <= '0;
    in_if.red_in   <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rst_n          <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_replication();
    test_row_padding();
    test_random_images(850);
    test_no_idle_stretch();
    test_output_hold_off();

    in_if.valid <= 1'b0;
    while (replicated_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && replicated_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/upr_pkg.sv
sv/upr_in_if.sv
sv/upr_out_if.sv
sv/upr_front.sv
sv/upr_fifo.sv
sv/upr_back.sv
sv/integer_pixel_replication_upscaler_top.sv
tb/testbench.sv
